>>> hw/rtl/sdis_pkg.sv
// ----------------------------------------------------------------------------
// sdis_pkg
// Types and codes shared by the SD card bring-up and read sequencer.
// ----------------------------------------------------------------------------
package sdis_pkg;

	localparam logic [1:0] FUNC_SWITCH = 2'd0;
	localparam logic [1:0] FUNC_START  = 2'd1;
	localparam logic [1:0] FUNC_DONE   = 2'd2;
	localparam logic [1:0] FUNC_READ   = 2'd3;

	localparam logic [1:0] CFG_RETRY_LIMIT    = 2'd0;
	localparam logic [1:0] CFG_VOLTAGE_WINDOW = 2'd1;
	localparam logic [1:0] CFG_BLOCK_LENGTH   = 2'd2;

	localparam logic [15:0] RETRY_LIMIT_RESET    = 16'd1000;
	localparam logic [23:0] VOLTAGE_WINDOW_RESET = 24'h300000;
	localparam logic [10:0] BLOCK_LENGTH_RESET   = 11'd512;

	localparam logic [2:0] OUT_PENDING     = 3'd0;
	localparam logic [2:0] OUT_INIT_OK     = 3'd1;
	localparam logic [2:0] OUT_INIT_FAILED = 3'd2;
	localparam logic [2:0] OUT_READ_OK     = 3'd3;
	localparam logic [2:0] OUT_READ_ERROR  = 3'd4;
	localparam logic [2:0] OUT_NOT_READY   = 3'd5;

	localparam logic [3:0] RESP_NONE   = 4'd0;
	localparam logic [3:0] RESP_R1     = 4'd1;
	localparam logic [3:0] RESP_R1B    = 4'd2;
	localparam logic [3:0] RESP_R2     = 4'd3;
	localparam logic [3:0] RESP_R3     = 4'd4;
	localparam logic [3:0] RESP_R6     = 4'd5;
	localparam logic [3:0] RESP_R7     = 4'd6;
	localparam logic [3:0] RESP_SINGLE = 4'd7;
	localparam logic [3:0] RESP_MULTI  = 4'd8;

	localparam logic [5:0] CMD_GO_IDLE     = 6'd0;
	localparam logic [5:0] CMD_ALL_CID     = 6'd2;
	localparam logic [5:0] CMD_SEND_RCA    = 6'd3;
	localparam logic [5:0] CMD_SET_BUS     = 6'd6;
	localparam logic [5:0] CMD_SELECT      = 6'd7;
	localparam logic [5:0] CMD_IF_COND     = 6'd8;
	localparam logic [5:0] CMD_GET_CSD     = 6'd9;
	localparam logic [5:0] CMD_BLOCKLEN    = 6'd16;
	localparam logic [5:0] CMD_READ_SINGLE = 6'd17;
	localparam logic [5:0] CMD_READ_MULTI  = 6'd18;
	localparam logic [5:0] CMD_OP_COND     = 6'd41;
	localparam logic [5:0] CMD_APP         = 6'd55;

	localparam logic [31:0] IF_COND_ECHO = 32'h0000_01AA;
	localparam logic [31:0] OCR_READY    = 32'h8000_0000;
	localparam logic [31:0] OP_COND_BITS = 32'h5000_0000;
	localparam logic [31:0] BUS_WIDTH_4  = 32'h0000_0002;

	typedef enum logic [11:0] {
		ST_IDLE   = 12'b0000_0000_0001,
		ST_CMD0   = 12'b0000_0000_0010,
		ST_CMD8   = 12'b0000_0000_0100,
		ST_LOOP55 = 12'b0000_0000_1000,
		ST_ACMD41 = 12'b0000_0001_0000,
		ST_CMD2   = 12'b0000_0010_0000,
		ST_CMD3   = 12'b0000_0100_0000,
		ST_CMD9   = 12'b0000_1000_0000,
		ST_CMD7   = 12'b0001_0000_0000,
		ST_BUS55  = 12'b0010_0000_0000,
		ST_ACMD6  = 12'b0100_0000_0000,
		ST_CMD16  = 12'b1000_0000_0000
	} seq_step_t;

	typedef struct packed {
		logic [1:0]  func;
		logic        card_present;
		logic        cmd_error;
		logic [31:0] response;
		logic [31:0] start_sector;
		logic [15:0] sector_count;
	} req_word_t;

	typedef struct packed {
		logic        issue;
		logic [5:0]  cmd_index;
		logic [31:0] cmd_arg;
		logic [3:0]  resp_kind;
		logic [15:0] block_count;
		logic        fast_clock;
		logic        wide_bus;
		logic        not_initialized;
		logic        no_disk;
		logic [2:0]  outcome;
	} rsp_word_t;

	typedef struct packed {
		logic [15:0] retry_limit;
		logic [23:0] voltage_window;
		logic [10:0] block_length;
	} cfg_regs_t;

	typedef struct packed {
		seq_step_t   step;
		logic [15:0] card_rca;
		logic [15:0] tries_left;
		logic        not_init;
		logic        no_disk;
		logic        read_pending;
	} seq_state_t;

endpackage

>>> hw/rtl/sdis_cfg_regs.sv
// ----------------------------------------------------------------------------
// sdis_cfg_regs
// Configuration registers of the sequencer, written through a plain port.
// ----------------------------------------------------------------------------
module sdis_cfg_regs (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [23:0]          cfg_data,
	output sdis_pkg::cfg_regs_t  cfg
);

	sdis_pkg::cfg_regs_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.retry_limit    <= sdis_pkg::RETRY_LIMIT_RESET;
			cfg_q.voltage_window <= sdis_pkg::VOLTAGE_WINDOW_RESET;
			cfg_q.block_length   <= sdis_pkg::BLOCK_LENGTH_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sdis_pkg::CFG_RETRY_LIMIT:    cfg_q.retry_limit    <= cfg_data[15:0];
				sdis_pkg::CFG_VOLTAGE_WINDOW: cfg_q.voltage_window <= cfg_data;
				sdis_pkg::CFG_BLOCK_LENGTH:   cfg_q.block_length   <= cfg_data[10:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> hw/rtl/sdis_seq_logic.sv
// ----------------------------------------------------------------------------
// sdis_seq_logic
// Next-state and command decision for one word against the sequencer state.
// ----------------------------------------------------------------------------
module sdis_seq_logic (
	input  sdis_pkg::req_word_t   req_word,
	input  sdis_pkg::seq_state_t  cur,
	input  sdis_pkg::cfg_regs_t   cfg,
	output sdis_pkg::seq_state_t  nxt,
	output sdis_pkg::rsp_word_t   rsp_word
);

	always_comb begin
		logic        busy;
		logic [31:0] rca_arg;
		logic [31:0] window;
		busy    = (cur.step != sdis_pkg::ST_IDLE) || cur.read_pending;
		rca_arg = {cur.card_rca, 16'h0000};
		window  = {8'h00, cfg.voltage_window};
		nxt     = cur;
		rsp_word = '0;

		unique case (req_word.func)
			sdis_pkg::FUNC_SWITCH: begin
				nxt.not_init     = 1'b1;
				nxt.no_disk      = !req_word.card_present;
				nxt.step         = sdis_pkg::ST_IDLE;
				nxt.read_pending = 1'b0;
			end
			sdis_pkg::FUNC_START: begin
				if (busy) begin
					rsp_word.outcome = sdis_pkg::OUT_NOT_READY;
				end else if (!cur.not_init) begin
					rsp_word.outcome = sdis_pkg::OUT_INIT_OK;
				end else if (cur.no_disk) begin
					rsp_word.outcome = sdis_pkg::OUT_INIT_FAILED;
				end else begin
					nxt.card_rca       = '0;
					nxt.tries_left     = '0;
					nxt.step           = sdis_pkg::ST_CMD0;
					rsp_word.issue     = 1'b1;
					rsp_word.cmd_index = sdis_pkg::CMD_GO_IDLE;
					rsp_word.resp_kind = sdis_pkg::RESP_NONE;
				end
			end
			sdis_pkg::FUNC_DONE: begin
				if (cur.read_pending) begin
					nxt.read_pending = 1'b0;
					rsp_word.outcome = req_word.cmd_error ? sdis_pkg::OUT_READ_ERROR
						: sdis_pkg::OUT_READ_OK;
				end else if (cur.step == sdis_pkg::ST_IDLE) begin
					rsp_word.outcome = sdis_pkg::OUT_PENDING;
				end else if (req_word.cmd_error) begin
					nxt.step         = sdis_pkg::ST_IDLE;
					rsp_word.outcome = sdis_pkg::OUT_INIT_FAILED;
				end else begin
					unique case (cur.step)
						sdis_pkg::ST_CMD0: begin
							rsp_word.issue     = 1'b1;
							rsp_word.cmd_index = sdis_pkg::CMD_IF_COND;
							rsp_word.cmd_arg   = sdis_pkg::IF_COND_ECHO;
							rsp_word.resp_kind = sdis_pkg::RESP_R7;
							nxt.step           = sdis_pkg::ST_CMD8;
						end
						sdis_pkg::ST_CMD8: begin
							if (req_word.response != sdis_pkg::IF_COND_ECHO) begin
								nxt.step         = sdis_pkg::ST_IDLE;
								rsp_word.outcome = sdis_pkg::OUT_INIT_FAILED;
							end else begin
								nxt.tries_left     = cfg.retry_limit;
								rsp_word.issue     = 1'b1;
								rsp_word.cmd_index = sdis_pkg::CMD_APP;
								rsp_word.cmd_arg   = rca_arg;
								rsp_word.resp_kind = sdis_pkg::RESP_R1;
								nxt.step           = sdis_pkg::ST_LOOP55;
							end
						end
						sdis_pkg::ST_LOOP55: begin
							rsp_word.issue     = 1'b1;
							rsp_word.cmd_index = sdis_pkg::CMD_OP_COND;
							rsp_word.cmd_arg   = sdis_pkg::OP_COND_BITS | window;
							rsp_word.resp_kind = sdis_pkg::RESP_R3;
							nxt.step           = sdis_pkg::ST_ACMD41;
						end
						sdis_pkg::ST_ACMD41: begin
							if ((req_word.response & window) == 32'h0) begin
								nxt.step         = sdis_pkg::ST_IDLE;
								rsp_word.outcome = sdis_pkg::OUT_INIT_FAILED;
							end else if (((req_word.response & sdis_pkg::OCR_READY) != 32'h0)
								|| (cur.tries_left <= 16'd1)) begin
								nxt.tries_left     = '0;
								rsp_word.issue     = 1'b1;
								rsp_word.cmd_index = sdis_pkg::CMD_ALL_CID;
								rsp_word.resp_kind = sdis_pkg::RESP_R2;
								nxt.step           = sdis_pkg::ST_CMD2;
							end else begin
								nxt.tries_left     = cur.tries_left - 16'd1;
								rsp_word.issue     = 1'b1;
								rsp_word.cmd_index = sdis_pkg::CMD_APP;
								rsp_word.cmd_arg   = rca_arg;
								rsp_word.resp_kind = sdis_pkg::RESP_R1;
								nxt.step           = sdis_pkg::ST_LOOP55;
							end
						end
						sdis_pkg::ST_CMD2: begin
							rsp_word.issue     = 1'b1;
							rsp_word.cmd_index = sdis_pkg::CMD_SEND_RCA;
							rsp_word.resp_kind = sdis_pkg::RESP_R6;
							nxt.step           = sdis_pkg::ST_CMD3;
						end
						sdis_pkg::ST_CMD3: begin
							nxt.card_rca       = req_word.response[31:16];
							rsp_word.issue     = 1'b1;
							rsp_word.cmd_index = sdis_pkg::CMD_GET_CSD;
							rsp_word.cmd_arg   = {req_word.response[31:16], 16'h0000};
							rsp_word.resp_kind = sdis_pkg::RESP_R2;
							nxt.step           = sdis_pkg::ST_CMD9;
						end
						sdis_pkg::ST_CMD9: begin
							rsp_word.fast_clock = 1'b1;
							rsp_word.issue      = 1'b1;
							rsp_word.cmd_index  = sdis_pkg::CMD_SELECT;
							rsp_word.cmd_arg    = rca_arg;
							rsp_word.resp_kind  = sdis_pkg::RESP_R1B;
							nxt.step            = sdis_pkg::ST_CMD7;
						end
						sdis_pkg::ST_CMD7: begin
							rsp_word.issue     = 1'b1;
							rsp_word.cmd_index = sdis_pkg::CMD_APP;
							rsp_word.cmd_arg   = rca_arg;
							rsp_word.resp_kind = sdis_pkg::RESP_R1;
							nxt.step           = sdis_pkg::ST_BUS55;
						end
						sdis_pkg::ST_BUS55: begin
							rsp_word.issue     = 1'b1;
							rsp_word.cmd_index = sdis_pkg::CMD_SET_BUS;
							rsp_word.cmd_arg   = sdis_pkg::BUS_WIDTH_4;
							rsp_word.resp_kind = sdis_pkg::RESP_R1;
							nxt.step           = sdis_pkg::ST_ACMD6;
						end
						sdis_pkg::ST_ACMD6: begin
							rsp_word.wide_bus  = 1'b1;
							rsp_word.issue     = 1'b1;
							rsp_word.cmd_index = sdis_pkg::CMD_BLOCKLEN;
							rsp_word.cmd_arg   = {21'h0, cfg.block_length};
							rsp_word.resp_kind = sdis_pkg::RESP_R1;
							nxt.step           = sdis_pkg::ST_CMD16;
						end
						default: begin
							nxt.not_init     = 1'b0;
							nxt.no_disk      = 1'b0;
							nxt.step         = sdis_pkg::ST_IDLE;
							rsp_word.outcome = sdis_pkg::OUT_INIT_OK;
						end
					endcase
				end
			end
			default: begin
				if (busy || cur.not_init) begin
					rsp_word.outcome = sdis_pkg::OUT_NOT_READY;
				end else if (req_word.sector_count == 16'd0) begin
					rsp_word.outcome = sdis_pkg::OUT_READ_ERROR;
				end else begin
					rsp_word.issue   = 1'b1;
					rsp_word.cmd_arg = req_word.start_sector;
					if (req_word.sector_count == 16'd1) begin
						rsp_word.cmd_index = sdis_pkg::CMD_READ_SINGLE;
						rsp_word.resp_kind = sdis_pkg::RESP_SINGLE;
					end else begin
						rsp_word.cmd_index   = sdis_pkg::CMD_READ_MULTI;
						rsp_word.resp_kind   = sdis_pkg::RESP_MULTI;
						rsp_word.block_count = req_word.sector_count;
					end
					nxt.step         = sdis_pkg::ST_IDLE;
					nxt.read_pending = 1'b1;
				end
			end
		endcase

		rsp_word.not_initialized = nxt.not_init;
		rsp_word.no_disk         = nxt.no_disk;
	end

endmodule

>>> hw/rtl/sd_card_init_and_read_sequencer_unit.sv
// ----------------------------------------------------------------------------
// sd_card_init_and_read_sequencer_unit
// Host-side SD card bring-up and block-read command sequencer.
// ----------------------------------------------------------------------------
// Each request word on req is an event: a card switch change, a start of
// bring-up, the completion of the last command, or a read request. For every
// request word exactly one response word leaves on rsp, telling whether a
// command goes out now, with its index, argument and response kind, the
// clock and bus pulses, the disk flags and the outcome.
// A request word is registered in the input register, decided against the
// sequencer state and placed in the output register, which drives rsp.
// One word is taken per cycle while req_stall is low; the input register
// and the output register each hold one word, so while rsp is stalled one
// more word is accepted and then req_stall rises until the output register
// is taken.
// Reset empties both registers, returns the sequencer to idle with the
// not-initialized and no-disk flags set and loads the register defaults.
// Configuration is written on cfg_we with cfg_index and cfg_data.
// ----------------------------------------------------------------------------
module sd_card_init_and_read_sequencer_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  sdis_pkg::req_word_t  req,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output sdis_pkg::rsp_word_t  rsp,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [23:0]          cfg_data
);

	sdis_pkg::cfg_regs_t  cfg;
	sdis_pkg::seq_state_t state_q;
	sdis_pkg::seq_state_t state_nxt;
	sdis_pkg::req_word_t  req_s1;
	sdis_pkg::rsp_word_t  rsp_nxt;
	sdis_pkg::rsp_word_t  rsp_s2;
	logic                 valid_s1;
	logic                 valid_s2;
	logic                 advance;

	sdis_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	sdis_seq_logic u_logic (
		.req_word (req_s1),
		.cur      (state_q),
		.cfg      (cfg),
		.nxt      (state_nxt),
		.rsp_word (rsp_nxt)
	);

	assign advance   = valid_s1 && (!valid_s2 || !rsp_stall);
	assign req_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q.step         <= sdis_pkg::ST_IDLE;
			state_q.card_rca     <= '0;
			state_q.tries_left   <= '0;
			state_q.not_init     <= 1'b1;
			state_q.no_disk      <= 1'b1;
			state_q.read_pending <= 1'b0;
		end else begin
			if (!req_stall) begin
				valid_s1 <= req_valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
				state_q  <= state_nxt;
			end else if (!rsp_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!req_stall && req_valid) begin
			req_s1 <= req;
		end
		if (advance) begin
			rsp_s2 <= rsp_nxt;
		end
	end

	assign rsp_valid = valid_s2;
	assign rsp       = rsp_s2;

endmodule
